// File: design/sitda_pkg.sv
// Shared constants and helpers for the signed integer to decimal ASCII block.
// No dependencies; used by the front end, the back end and the top level.
package sitda_pkg;

    localparam int DIGIT_BITS = 4;            // one BCD digit
    localparam int SHIFTS_PER_STEP = 4;       // binary bits consumed per conversion cycle
    localparam int CHAR_BITS = 6;

    localparam logic [CHAR_BITS-1:0] ASCII_ZERO  = 6'd48;
    localparam logic [CHAR_BITS-1:0] ASCII_MINUS = 6'd45;
    localparam logic [DIGIT_BITS-1:0] DIGIT_NINE = 4'd9;

    // Decimal digits of the largest magnitude, 2^(vb-1): floor((vb-1)*log10(2)) + 1
    function automatic int digits_for_bits(input int vb);
        return ((vb - 1) * 30103) / 100000 + 1;
    endfunction

endpackage

// File: design/sitda_front.sv
// Front end: accepts a signed value, forms its magnitude and converts it to BCD
// by shift-and-add-3, four bits per cycle. Depends on sitda_pkg.
module sitda_front #(
    parameter int VALUE_BITS = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [VALUE_BITS-1:0] in_value,
    output logic                  q_valid,
    input  logic                  q_ready,
    // {neg, digit count, BCD digits}
    output logic [1+$clog2(sitda_pkg::digits_for_bits(VALUE_BITS)+1)
                  +sitda_pkg::digits_for_bits(VALUE_BITS)*sitda_pkg::DIGIT_BITS-1:0] q_data
);

    localparam int NDIG  = sitda_pkg::digits_for_bits(VALUE_BITS);
    localparam int DW    = sitda_pkg::DIGIT_BITS;
    localparam int SPS   = sitda_pkg::SHIFTS_PER_STEP;
    localparam int STEPS = (VALUE_BITS + SPS - 1) / SPS;
    localparam int PADW  = STEPS * SPS;
    localparam int CW    = $clog2(STEPS);
    localparam int LW    = $clog2(NDIG + 1);
    localparam int BW    = NDIG * DW;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_PUSH = 2'd2;

    logic [1:0]      state_reg, state_next;
    logic [CW-1:0]   step_reg, step_next;
    logic [PADW-1:0] bin_reg, bin_next;
    logic [BW-1:0]   bcd_reg, bcd_next;
    logic            neg_reg, neg_next;

    logic [VALUE_BITS-1:0] mag;
    logic [BW-1:0]         bcd_step;
    logic [PADW-1:0]       bin_step;
    logic [LW-1:0]         len;

    assign in_ready = (state_reg == ST_IDLE);
    assign q_valid  = (state_reg == ST_PUSH);
    assign q_data   = {neg_reg, len, bcd_reg};

    // unsigned negate also covers the most negative value
    assign mag = in_value[VALUE_BITS-1] ? (~in_value + 1'b1) : in_value;

    always_comb
    begin
        logic [BW-1:0]   b;
        logic [PADW-1:0] s;
        b = bcd_reg;
        s = bin_reg;
        for (int k = 0; k < SPS; k++)
        begin
            for (int d = 0; d < NDIG; d++)
            begin
                if (b[d*DW +: DW] >= 4'd5)
                begin
                    b[d*DW +: DW] = b[d*DW +: DW] + 4'd3;
                end
            end
            b = {b[BW-2:0], s[PADW-1]};
            s = {s[PADW-2:0], 1'b0};
        end
        bcd_step = b;
        bin_step = s;
    end

    // digit count: position of the highest nonzero digit, at least one
    always_comb
    begin
        len = LW'(1);
        for (int i = 0; i < NDIG; i++)
        begin
            if (bcd_reg[i*DW +: DW] != '0)
            begin
                len = LW'(i + 1);
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        bin_next   = bin_reg;
        bcd_next   = bcd_reg;
        neg_next   = neg_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    bin_next   = PADW'(mag);
                    bcd_next   = '0;
                    neg_next   = in_value[VALUE_BITS-1];
                    step_next  = CW'(STEPS - 1);
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                bin_next = bin_step;
                bcd_next = bcd_step;
                if (step_reg == '0)
                begin
                    state_next = ST_PUSH;
                end
                else
                begin
                    step_next = step_reg - 1'b1;
                end
            end
            ST_PUSH:
            begin
                if (q_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
        neg_reg <= neg_next;
    end

endmodule

// File: design/sitda_fifo.sv
// Two-entry request queue between the front and back ends.
// No dependencies; entry width is a parameter.
module sitda_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_valid,
    output logic             wr_ready,
    input  logic [WIDTH-1:0] wr_data,
    output logic             rd_valid,
    input  logic             rd_ready,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] entry_reg [2];
    logic             wr_ptr_reg, rd_ptr_reg;
    logic [1:0]       count_reg, count_next;
    logic             do_wr, do_rd;

    assign wr_ready = (count_reg != 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign rd_data  = entry_reg[rd_ptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    always_comb
    begin
        count_next = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_wr)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// File: design/sitda_back.sv
// Back end: takes a converted request from the queue and sends its characters,
// sign first, most significant digit first. Depends on sitda_pkg.
module sitda_back #(
    parameter int VALUE_BITS = 32
) (
    input  logic clk,
    input  logic rst_n,
    input  logic q_valid,
    output logic q_ready,
    input  logic [1+$clog2(sitda_pkg::digits_for_bits(VALUE_BITS)+1)
                  +sitda_pkg::digits_for_bits(VALUE_BITS)*sitda_pkg::DIGIT_BITS-1:0] q_data,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [sitda_pkg::CHAR_BITS-1:0]  out_char,
    output logic                             out_last
);

    localparam int NDIG = sitda_pkg::digits_for_bits(VALUE_BITS);
    localparam int DW   = sitda_pkg::DIGIT_BITS;
    localparam int LW   = $clog2(NDIG + 1);
    localparam int IW   = (NDIG > 1) ? $clog2(NDIG) : 1;
    localparam int BW   = NDIG * DW;

    logic          busy_reg, busy_next;
    logic          sign_reg, sign_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic [BW-1:0] bcd_reg, bcd_next;

    logic          q_neg;
    logic [LW-1:0] q_len;
    logic [BW-1:0] q_bcd;
    logic [DW-1:0] digit;
    logic          out_fire;

    assign {q_neg, q_len, q_bcd} = q_data;

    assign digit     = bcd_reg[idx_reg*DW +: DW];
    assign out_valid = busy_reg;
    assign out_char  = sign_reg ? sitda_pkg::ASCII_MINUS
                                : (sitda_pkg::ASCII_ZERO + sitda_pkg::CHAR_BITS'(digit));
    assign out_last  = !sign_reg && (idx_reg == '0);
    assign out_fire  = out_valid && out_ready;
    // take the next request as the final character of this one leaves
    assign q_ready   = !busy_reg || (out_fire && out_last);

    always_comb
    begin
        busy_next = busy_reg;
        sign_next = sign_reg;
        idx_next  = idx_reg;
        bcd_next  = bcd_reg;
        if (q_ready && q_valid)
        begin
            busy_next = 1'b1;
            sign_next = q_neg;
            idx_next  = IW'(q_len - 1'b1);
            bcd_next  = q_bcd;
        end
        else if (out_fire)
        begin
            if (sign_reg)
            begin
                sign_next = 1'b0;
            end
            else if (idx_reg == '0)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                idx_next = idx_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            sign_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            sign_reg <= sign_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bcd_reg <= bcd_next;
    end

    a_char_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_char == sitda_pkg::ASCII_MINUS) ||
                      (!sign_reg && digit <= sitda_pkg::DIGIT_NINE))
        else $error("character outside '-' and digits");

    a_sign_then_digit: assert property (@(posedge clk) disable iff (!rst_n)
        (out_fire && sign_reg) |=> (out_valid && !sign_reg))
        else $error("sign not followed by a digit");

    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        (q_valid && q_ready) |=> out_valid)
        else $error("loaded request not presented");

endmodule

// File: design/signed_int_to_decimal_ascii.sv
// Top level of the signed integer to decimal ASCII converter.
// Depends on sitda_pkg, sitda_front, sitda_fifo and sitda_back.
//
//  channel | dir | fields (tdata from bit 0 up)     | tlast
//  s_axis  | in  | value (VALUE_BITS, signed)        | -
//  m_axis  | out | ascii_char (6 bits)               | last_char
//
// The front end accepts a number, converts it by shift-and-add-3 four bits at a
// time and hands it to the queue. The back end sends one character per cycle
// while m_axis is ready, up to 11 characters at 32 bits; the queue lets the front
// convert the next number while the back sends the current one.
// Reset clears the control state and empties the queue.
// A stalled m_axis holds its character; the front fills the queue meanwhile.
module signed_int_to_decimal_ascii #(
    parameter int VALUE_BITS = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [((VALUE_BITS+7)/8)*8-1:0]   s_axis_tdata,   // value
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [7:0]                        m_axis_tdata,   // ascii_char, 2 zero bits
    output logic                              m_axis_tlast    // last_char
);

    localparam int NDIG = sitda_pkg::digits_for_bits(VALUE_BITS);
    localparam int QW   = 1 + $clog2(NDIG + 1) + NDIG * sitda_pkg::DIGIT_BITS;

    logic          fq_valid, fq_ready;
    logic [QW-1:0] fq_data;
    logic          qb_valid, qb_ready;
    logic [QW-1:0] qb_data;
    logic [sitda_pkg::CHAR_BITS-1:0] out_char;

    sitda_front #(.VALUE_BITS(VALUE_BITS)) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_value (s_axis_tdata[VALUE_BITS-1:0]),
        .q_valid  (fq_valid),
        .q_ready  (fq_ready),
        .q_data   (fq_data)
    );

    sitda_fifo #(.WIDTH(QW)) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (fq_valid),
        .wr_ready (fq_ready),
        .wr_data  (fq_data),
        .rd_valid (qb_valid),
        .rd_ready (qb_ready),
        .rd_data  (qb_data)
    );

    sitda_back #(.VALUE_BITS(VALUE_BITS)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (qb_valid),
        .q_ready   (qb_ready),
        .q_data    (qb_data),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_char  (out_char),
        .out_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {2'b00, out_char};

endmodule
